// ----- src/prst_pkg.sv -----
// ----------------------------------------------------------------------------
// prst_pkg - shared types and constants for the parent ready slot tracker
// Entry layout, chain control bundle, command, error and state codes.
// ----------------------------------------------------------------------------
package prst_pkg;

    // Entries held in each of the two chains
    localparam int TABLE_CAP = 8;
    localparam int WORD_W    = 64;

    // Block id: slot first, then hash words in compare order. As a packed
    // vector its unsigned order is the lexicographic id order.
    typedef struct packed {
        logic [WORD_W-1:0] slot;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
    } entry_t;

    // Per-cycle control broadcast along a chain
    typedef struct packed {
        logic shift;   // every cell takes its neighbour's entry
        logic clear;   // drop all entries
        logic seed;    // with clear: head cell holds the all-zero entry
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_SKIP     = 2'd1,
        CMD_FALLBACK = 2'd2,
        CMD_READY    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_FB_FULL    = 2'd1,
        ERR_READY_DUP  = 2'd2,
        ERR_READY_FULL = 2'd3
    } err_t;

    typedef enum logic {
        ST_LOAD = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

// ----- src/prst_cell.sv -----
// ----------------------------------------------------------------------------
// prst_cell - one storage cell of a tracker chain
// Holds one entry and its valid bit, compares it with the broadcast key.
// ----------------------------------------------------------------------------
module prst_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  prst_pkg::chain_ctrl_t ctrl,
    input  prst_pkg::entry_t      prev_entry,
    input  logic                  prev_valid,
    input  prst_pkg::entry_t      key,
    output prst_pkg::entry_t      entry,
    output logic                  valid,
    output logic                  match
);

    prst_pkg::entry_t entry_reg;
    logic             valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= ctrl.seed;
        end else if (ctrl.shift) begin
            valid_reg <= prev_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            if (ctrl.seed) begin
                entry_reg <= '0;
            end
        end else if (ctrl.shift) begin
            entry_reg <= prev_entry;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (entry_reg == key);

endmodule

// ----- src/prst_chain.sv -----
// ----------------------------------------------------------------------------
// prst_chain - row of TABLE_CAP cells forming a duplicate-free set
// New entries enter at the head and push older ones one cell along.
// ----------------------------------------------------------------------------
module prst_chain (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  prst_pkg::chain_ctrl_t ctrl,
    input  prst_pkg::entry_t      key,
    output logic                  hit,
    output logic                  full
);

    prst_pkg::entry_t                  cell_entry [prst_pkg::TABLE_CAP];
    logic [prst_pkg::TABLE_CAP-1:0]    cell_valid;
    logic [prst_pkg::TABLE_CAP-1:0]    cell_match;

    for (genvar i = 0; i < prst_pkg::TABLE_CAP; i++) begin : g_cell
        prst_pkg::chain_ctrl_t c_ctrl;
        prst_pkg::entry_t      p_entry;
        logic                  p_valid;

        always_comb begin
            c_ctrl      = ctrl;
            c_ctrl.seed = (i == 0) ? ctrl.seed : 1'b0;
        end

        if (i == 0) begin : g_head
            assign p_entry = key;
            assign p_valid = 1'b1;
        end else begin : g_body
            assign p_entry = cell_entry[i-1];
            assign p_valid = cell_valid[i-1];
        end

        prst_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (c_ctrl),
            .prev_entry (p_entry),
            .prev_valid (p_valid),
            .key        (key),
            .entry      (cell_entry[i]),
            .valid      (cell_valid[i]),
            .match      (cell_match[i])
        );
    end

    assign hit  = |cell_match;
    // valid bits fill from the head, so the tail cell tells fullness
    assign full = cell_valid[prst_pkg::TABLE_CAP-1];

endmodule

// ----- src/parent_ready_slot_tracker.sv -----
// ----------------------------------------------------------------------------
// parent_ready_slot_tracker - skip, fallback and ready-id tracking for a slot
// Two cell chains hold the fallback hash set and the ready id table.
// ----------------------------------------------------------------------------
// Usage
//   Input channel s_*: one command per transfer (clear, mark skip, add
//   fallback hash, add ready id) with the slot and hash words.
//   Output channel m_*: exactly one result per input transfer, in order,
//   giving accepted, error code, skip and ready flags and the smallest
//   ready id so far (all zero while no ready id is held).
//   cfg_wr_en/cfg_wr_data write genesis_start; it is used at the next clear.
// Timing
//   A command is taken into a key register (load step), then every cell of
//   both chains compares against it in parallel and the state and result
//   register are updated (execute step). The result is registered. Load
//   and execute steps alternate, so a new command is taken only after the
//   previous one has been executed.
// Reset / stall
//   Synchronous active-low reset empties both chains, clears flags and the
//   minimum and sets genesis_start to 0. While m_ready is low a finished
//   result is held; the next command is still taken in, but its execute
//   step waits until the output register is free.
// ----------------------------------------------------------------------------
module parent_ready_slot_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // command input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [63:0] s_id_slot,
    input  logic [63:0] s_hash_w0,
    input  logic [63:0] s_hash_w1,
    input  logic [63:0] s_hash_w2,
    input  logic [63:0] s_hash_w3,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [1:0]  m_error,
    output logic        m_skip_flag,
    output logic        m_ready_flag,
    output logic [63:0] m_best_slot,
    output logic [63:0] m_best_w0,
    output logic [63:0] m_best_w1,
    output logic [63:0] m_best_w2,
    output logic [63:0] m_best_w3
);

    prst_pkg::state_t      state_reg, state_next;
    prst_pkg::cmd_t        cmd_reg;
    prst_pkg::entry_t      key_reg;
    prst_pkg::entry_t      fb_key;
    logic                  genesis_reg;

    logic                  skip_reg, skip_next;
    logic                  rdy_bit_reg, rdy_bit_next;
    prst_pkg::entry_t      min_reg, min_next;

    logic                  m_valid_reg;
    logic                  acc_reg, acc_next;
    prst_pkg::err_t        err_reg, err_next;

    prst_pkg::chain_ctrl_t fb_ctrl, rd_ctrl;
    logic                  fb_hit, fb_full, rd_hit, rd_full;
    logic                  take, commit, id_smaller;

    // --- configuration register ---
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            genesis_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            genesis_reg <= cfg_wr_data;
        end
    end

    // --- handshake / sequencing ---
    always_comb begin
        s_ready = (state_reg == prst_pkg::ST_LOAD);
        take    = s_valid && s_ready;
        commit  = (state_reg == prst_pkg::ST_EXEC) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prst_pkg::ST_LOAD: if (take)   state_next = prst_pkg::ST_EXEC;
            prst_pkg::ST_EXEC: if (commit) state_next = prst_pkg::ST_LOAD;
            default:                       state_next = prst_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prst_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // key capture (payload, no reset)
    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= prst_pkg::cmd_t'(s_cmd);
            key_reg <= '{slot: s_id_slot, w0: s_hash_w0, w1: s_hash_w1,
                         w2: s_hash_w2, w3: s_hash_w3};
        end
    end

    // fallback set stores hashes only: slot forced to zero
    always_comb begin
        fb_key      = key_reg;
        fb_key.slot = '0;
    end

    // --- cell chains ---
    prst_chain u_fb_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fb_ctrl),
        .key     (fb_key),
        .hit     (fb_hit),
        .full    (fb_full)
    );

    prst_chain u_rd_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rd_ctrl),
        .key     (key_reg),
        .hit     (rd_hit),
        .full    (rd_full)
    );

    // packed order of entry_t is the id order
    assign id_smaller = (key_reg < min_reg);

    // --- execute step: decision and next state ---
    always_comb begin
        fb_ctrl      = '0;
        rd_ctrl      = '0;
        skip_next    = skip_reg;
        rdy_bit_next = rdy_bit_reg;
        min_next     = min_reg;
        acc_next     = 1'b0;
        err_next     = prst_pkg::ERR_NONE;
        if (commit) begin
            unique case (cmd_reg)
                prst_pkg::CMD_CLEAR: begin
                    fb_ctrl.clear = 1'b1;
                    fb_ctrl.seed  = genesis_reg;
                    rd_ctrl.clear = 1'b1;
                    skip_next     = 1'b0;
                    rdy_bit_next  = 1'b0;
                    min_next      = '0;
                    acc_next      = 1'b1;
                end
                prst_pkg::CMD_SKIP: begin
                    acc_next  = !skip_reg;
                    skip_next = 1'b1;
                end
                prst_pkg::CMD_FALLBACK: begin
                    // presence is checked before fullness
                    priority if (fb_hit) begin
                        acc_next = 1'b0;
                    end else if (fb_full) begin
                        err_next = prst_pkg::ERR_FB_FULL;
                    end else begin
                        fb_ctrl.shift = 1'b1;
                        acc_next      = 1'b1;
                    end
                end
                prst_pkg::CMD_READY: begin
                    priority if (rd_hit) begin
                        err_next = prst_pkg::ERR_READY_DUP;
                    end else if (rd_full) begin
                        err_next = prst_pkg::ERR_READY_FULL;
                    end else begin
                        rd_ctrl.shift = 1'b1;
                        acc_next      = 1'b1;
                        rdy_bit_next  = 1'b1;
                        if (!rdy_bit_reg || id_smaller) begin
                            min_next = key_reg;
                        end
                    end
                end
                default: begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg    <= 1'b0;
            rdy_bit_reg <= 1'b0;
            min_reg     <= '0;
        end else begin
            skip_reg    <= skip_next;
            rdy_bit_reg <= rdy_bit_next;
            min_reg     <= min_next;
        end
    end

    // --- output register ---
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

    // flags and minimum are read straight from state: it only changes on
    // a commit, which also reloads the output register
    assign m_valid      = m_valid_reg;
    assign m_accepted   = acc_reg;
    assign m_error      = err_reg;
    assign m_skip_flag  = skip_reg;
    assign m_ready_flag = rdy_bit_reg;
    assign m_best_slot  = min_reg.slot;
    assign m_best_w0    = min_reg.w0;
    assign m_best_w1    = min_reg.w1;
    assign m_best_w2    = min_reg.w2;
    assign m_best_w3    = min_reg.w3;

    // --- checks ---
    a_acc_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_accepted && m_error != prst_pkg::ERR_NONE))
        else $error("result both accepted and in error");

    a_best_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready_flag) |-> (m_best_slot == '0 && m_best_w0 == '0
            && m_best_w1 == '0 && m_best_w2 == '0 && m_best_w3 == '0))
        else $error("best id not zero while no ready id held");

    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == prst_pkg::ST_EXEC))
        else $error("result raised outside execute step");

    a_no_take_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == prst_pkg::ST_EXEC && !commit) |=> (state_reg == prst_pkg::ST_EXEC))
        else $error("execute step left without commit");

endmodule
